@@ rtl/pord_pkg.sv @@
`default_nettype none

package pord_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned KW         = 4;
  localparam int unsigned CountW     = 16;
  localparam int unsigned OffW       = 32;
  localparam int unsigned ShortW     = 20;
  localparam int unsigned MaxOffs    = 4;
  localparam int unsigned QueueDepth = 4;

  localparam logic [KW-1:0]     RemBitsReset  = 4'd4;
  localparam logic [CountW-1:0] EntryCntReset = 16'd0;

  localparam logic CfgRemBits  = 1'b0;
  localparam logic CfgEntryCnt = 1'b1;

  localparam logic KindOffset = 1'b0;
  localparam logic KindFlag   = 1'b1;

  typedef struct packed {
    logic                            kind;
    logic [3:0]                      cnt;
    logic [CountW-1:0]               base_idx;
    logic [ByteW-1:0]                flags;
    logic [OffW-1:0]                 len0;
    logic [MaxOffs-2:0][ShortW-1:0]  len_s;
  } batch_t;

endpackage

`default_nettype wire

@@ rtl/phrase_offset_rice_decoder.sv @@
// Phrase offset Rice decoder.
// Input channel: one stream byte per beat (in_valid_i / in_stall_o), bits
// taken least significant first. Output channel: one result per beat
// (out_valid_o / out_stall_i): kind 0 carries a running end offset, kind 1 a
// phrase flag; last_o marks the final result of its byte.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 = remainder bits k, 1 = entry count); write only while idle.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; the result serializer emits one beat per
// cycle while not stalled, so a byte with several results takes one beat for
// each. Bytes are decoded combinationally by the front and queued as batches
// of up to 8 results. The first result of a byte passes through the batch
// queue and then the output register.
// A stalled receiver holds the output register; the front keeps taking bytes
// until the batch queue (QueueDepth batches) fills, then raises in_stall_o.
// Reset: k = 4, entry count 0, decoder waits for the first offset entry,
// running offset 0. No clearing pass.
`default_nettype none

module phrase_offset_rice_decoder #(
  parameter int unsigned QueueDepth = pord_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pord_pkg::CountW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pord_pkg::ByteW-1:0]   stream_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [pord_pkg::CountW-1:0]  entry_index_o,
  output logic [pord_pkg::OffW-1:0]    offset_o,
  output logic                         flag_o,
  output logic                         last_o
);
  import pord_pkg::*;

  logic [KW-1:0]     rem_bits_q;
  logic [CountW-1:0] entry_cnt_q;
  logic              push, pop, full, empty;
  batch_t            wr_batch, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_bits_q  <= RemBitsReset;
      entry_cnt_q <= EntryCntReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRemBits:  rem_bits_q  <= cfg_data_i[KW-1:0];
        CfgEntryCnt: entry_cnt_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full;

  pord_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .stream_byte_i (stream_byte_i),
    .rem_bits_i    (rem_bits_q),
    .entry_cnt_i   (entry_cnt_q),
    .q_full_i      (full),
    .push_o        (push),
    .batch_o       (wr_batch)
  );

  pord_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_batch),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  pord_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .entry_index_o (entry_index_o),
    .offset_o      (offset_o),
    .flag_o        (flag_o),
    .last_o        (last_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("batch pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("batch popped from empty queue");

  a_flag_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindFlag) |-> (offset_o == '0))
    else $error("flag result carries an offset");

  a_offset_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindOffset) |-> !flag_o)
    else $error("offset result carries a flag");

endmodule

`default_nettype wire

@@ rtl/pord_front.sv @@
`default_nettype none

module pord_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [pord_pkg::ByteW-1:0]    stream_byte_i,
  input  logic [pord_pkg::KW-1:0]       rem_bits_i,
  input  logic [pord_pkg::CountW-1:0]   entry_cnt_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output pord_pkg::batch_t              batch_o
);
  import pord_pkg::*;

  typedef enum logic [1:0] {PhOffs, PhSkip, PhFlag, PhDone} phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        gpos_q, gpos_d;
  logic              inr_q, inr_d;
  logic [2:0]        rpos_q, rpos_d;
  logic [OffW-1:0]   acc_q, acc_d;
  logic [CountW-1:0] done_q, done_d;

  logic              accept;
  logic [8:0]        eq;
  logic [MaxOffs:0]  geo;
  logic [7:0]        gef;
  logic [CountW-1:0] fbase;
  logic [2:0]        r;
  logic [2:0]        nd;
  logic [3:0]        nf;
  logic              stop, stop0, fstop, flag_now;
  logic [ShortW-1:0] dl [MaxOffs];
  logic [ShortW-1:0] delta_cur;
  logic [OffW-1:0]   len0, acc_next;
  logic              inr_e;
  logic [2:0]        rpos_e;

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    logic [CountW-1:0] s;
    for (int i = 0; i < 9; i++) begin
      eq[i] = (acc_q + (32'(i) << rem_bits_i)) == 32'd1;
    end
    for (int j = 0; j <= MaxOffs; j++) begin
      s = done_q + CountW'(j);
      geo[j] = s >= entry_cnt_i;
    end
    fbase = (phase_q == PhFlag) ? done_q : '0;
    for (int j = 0; j < 8; j++) begin
      s = fbase + CountW'(j);
      gef[j] = s >= entry_cnt_i;
    end
  end

  always_comb begin
    if (rem_bits_i == '0) begin
      r = 3'd1;
    end else if (rem_bits_i > 4'd5) begin
      r = 3'd5;
    end else begin
      r = rem_bits_i[2:0];
    end
  end

  always_comb begin
    logic [3:0] m;
    logic [4:0] rem;
    logic       bnd;
    m      = '0;
    rem    = '0;
    inr_e  = inr_q;
    rpos_e = rpos_q;
    nd     = '0;
    stop   = 1'b0;
    stop0  = 1'b0;
    bnd    = 1'b0;
    for (int e = 0; e < MaxOffs; e++) begin
      dl[e] = '0;
    end
    for (int b = 0; b < 8; b++) begin
      if (phase_q == PhOffs && !stop) begin
        bnd = !inr_e && ((nd == '0) ? eq[m] : (m == '0));
        if (bnd && geo[nd]) begin
          stop  = 1'b1;
          stop0 = (b == 0);
        end else if (!inr_e) begin
          if (stream_byte_i[b]) begin
            m = m + 4'd1;
          end else begin
            inr_e = 1'b1;
          end
        end else begin
          if (stream_byte_i[b] && rpos_e < 3'd5) begin
            rem = rem | (5'd1 << rpos_e);
          end
          rpos_e = rpos_e + 3'd1;
          if (rpos_e >= r) begin
            if (nd < 3'(MaxOffs)) begin
              dl[nd[1:0]] = (ShortW'(m) << rem_bits_i) + ShortW'(rem);
            end
            nd     = nd + 3'd1;
            m      = '0;
            rem    = '0;
            inr_e  = 1'b0;
            rpos_e = '0;
          end
        end
      end
    end
    delta_cur = (ShortW'(m) << rem_bits_i) + ShortW'(rem);
  end

  always_comb begin
    nf    = '0;
    fstop = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!fstop) begin
        if (gef[j]) begin
          fstop = 1'b1;
        end else begin
          nf = nf + 4'd1;
        end
      end
    end
  end

  assign len0     = acc_q + OffW'(dl[0]);
  assign acc_next = ((nd == '0) ? acc_q : 32'd1) + OffW'(delta_cur);
  assign flag_now = (phase_q == PhFlag) ||
                    (phase_q == PhOffs && stop && stop0 && gpos_q == 2'd0);

  always_comb begin
    phase_d = phase_q;
    gpos_d  = gpos_q;
    inr_d   = inr_q;
    rpos_d  = rpos_q;
    acc_d   = acc_q;
    done_d  = done_q;
    unique case (phase_q)
      PhOffs: begin
        if (stop) begin
          inr_d  = 1'b0;
          rpos_d = '0;
          acc_d  = 32'd1;
          if (stop0 && gpos_q == 2'd0) begin
            done_d  = CountW'(nf);
            phase_d = fstop ? PhDone : PhFlag;
          end else begin
            done_d  = '0;
            gpos_d  = gpos_q + 2'd1;
            phase_d = (gpos_q == 2'd3) ? PhFlag : PhSkip;
          end
        end else begin
          gpos_d = gpos_q + 2'd1;
          inr_d  = inr_e;
          rpos_d = rpos_e;
          acc_d  = acc_next;
          done_d = done_q + CountW'(nd);
        end
      end
      PhSkip: begin
        gpos_d = gpos_q + 2'd1;
        if (gpos_q == 2'd3) begin
          phase_d = PhFlag;
        end
      end
      PhFlag: begin
        done_d = done_q + CountW'(nf);
        if (fstop) begin
          phase_d = PhDone;
        end
      end
      PhDone: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    batch_o.flags = stream_byte_i;
    batch_o.len0  = len0;
    for (int e = 1; e < MaxOffs; e++) begin
      batch_o.len_s[e-1] = dl[e] + ShortW'(1);
    end
    if (flag_now) begin
      batch_o.kind     = KindFlag;
      batch_o.cnt      = nf;
      batch_o.base_idx = fbase;
      push_o           = accept && (nf != '0);
    end else begin
      batch_o.kind     = KindOffset;
      batch_o.cnt      = 4'(nd);
      batch_o.base_idx = done_q;
      push_o           = accept && (phase_q == PhOffs) && (nd != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOffs;
      gpos_q  <= '0;
      inr_q   <= 1'b0;
      rpos_q  <= '0;
      acc_q   <= 32'd1;
      done_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      gpos_q  <= gpos_d;
      inr_q   <= inr_d;
      rpos_q  <= rpos_d;
      acc_q   <= acc_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pord_queue.sv @@
`default_nettype none

module pord_queue #(
  parameter int unsigned Depth = pord_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pord_pkg::batch_t data_i,
  input  logic             pop_i,
  output pord_pkg::batch_t data_o,
  output logic             full_o,
  output logic             empty_o
);
  import pord_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  batch_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pord_back.sv @@
`default_nettype none

module pord_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pord_pkg::batch_t             head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [pord_pkg::CountW-1:0]  entry_index_o,
  output logic [pord_pkg::OffW-1:0]    offset_o,
  output logic                         flag_o,
  output logic                         last_o
);
  import pord_pkg::*;

  logic              out_valid_q;
  logic [2:0]        j_q;
  logic [OffW-1:0]   off_q;
  logic              load, is_last;
  logic [OffW-1:0]   sel_len, sum;

  assign load    = !empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = ({1'b0, j_q} == (head_i.cnt - 4'd1));
  assign pop_o   = load && is_last;
  assign sel_len = (j_q == '0) ? head_i.len0 : OffW'(head_i.len_s[2'(j_q - 3'd1)]);
  assign sum     = off_q + sel_len;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      j_q         <= '0;
      off_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      j_q         <= is_last ? '0 : j_q + 3'd1;
      if (head_i.kind == KindOffset) begin
        off_q <= sum;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o        <= head_i.kind;
      entry_index_o <= head_i.base_idx + CountW'(j_q);
      offset_o      <= (head_i.kind == KindOffset) ? sum : '0;
      flag_o        <= (head_i.kind == KindFlag) ? head_i.flags[j_q] : 1'b0;
      last_o        <= is_last;
    end
  end

endmodule

`default_nettype wire

@@ verif/phrase_offset_rice_decoder_test.sv @@
`timescale 1ns / 100ps

module phrase_offset_rice_decoder_test;
  import pord_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [1:0] {DecOffsets, DecSkip, DecFlags, DecDone} dec_phase_e;

  typedef struct packed {
    logic              kind;
    logic [CountW-1:0] idx;
    logic [OffW-1:0]   off;
    logic              flag;
    logic              last;
  } phrase_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CfgRemBits;
  logic [CountW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  stream_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              kind_o;
  logic [CountW-1:0] entry_index_o;
  logic [OffW-1:0]   offset_o;
  logic              flag_o;
  logic              last_o;

  logic [ByteW-1:0] stream_q [$];
  phrase_res_t      expect_q [$];
  phrase_res_t      seen;
  phrase_res_t      want;
  int               miss_cnt = 0;
  int               quiet_cycles = 0;
  int               hold_left = 0;
  bit               hold_req = 1'b0;
  bit               hold_taken = 1'b0;
  bit               calm = 1'b0;

  logic [KW-1:0]     rice_k = RemBitsReset;
  logic [CountW-1:0] entry_limit = EntryCntReset;
  dec_phase_e        dec_ph = DecOffsets;
  logic [1:0]        grp_pos = '0;
  logic              in_rem = 1'b0;
  logic [2:0]        rem_pos = '0;
  logic [OffW-1:0]   len_acc = 32'd1;
  logic [OffW-1:0]   run_off = '0;
  logic [CountW-1:0] done_cnt = '0;

  phrase_offset_rice_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .entry_index_o (entry_index_o),
    .offset_o      (offset_o),
    .flag_o        (flag_o),
    .last_o        (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic decode_byte(input logic [ByteW-1:0] b);
    phrase_res_t res [8];
    int          n;
    int          i;
    bit          flag_now;
    logic [2:0]  r;
    n = 0;
    flag_now = 1'b0;
    case (dec_ph)
      DecSkip: begin
        grp_pos = grp_pos + 2'd1;
        if (grp_pos == 2'd0) dec_ph = DecFlags;
      end
      DecFlags: flag_now = 1'b1;
      DecOffsets: begin
        for (i = 0; i < 8; i++) begin
          r = (rice_k < 1) ? 3'd1 : ((rice_k > 5) ? 3'd5 : rice_k[2:0]);
          if (!in_rem && len_acc == 32'd1 && done_cnt >= entry_limit) begin
            done_cnt = '0;
            if (i == 0 && grp_pos == 2'd0) begin
              dec_ph = DecFlags;
              flag_now = 1'b1;
            end else begin
              grp_pos = grp_pos + 2'd1;
              dec_ph = (grp_pos == 2'd0) ? DecFlags : DecSkip;
            end
            break;
          end
          if (!in_rem) begin
            if (b[i]) len_acc = len_acc + (32'd1 << rice_k);
            else in_rem = 1'b1;
          end else begin
            if (b[i] && rem_pos < 3'd5) len_acc = len_acc + (32'd1 << rem_pos);
            rem_pos = rem_pos + 3'd1;
            if (rem_pos >= r) begin
              run_off = run_off + len_acc;
              res[n] = '{KindOffset, done_cnt, run_off, 1'b0, 1'b0};
              n++;
              done_cnt = done_cnt + 16'd1;
              len_acc = 32'd1;
              in_rem = 1'b0;
              rem_pos = '0;
            end
          end
        end
        if (dec_ph == DecOffsets) grp_pos = grp_pos + 2'd1;
      end
      default: ;
    endcase
    if (flag_now) begin
      for (i = 0; i < 8; i++) begin
        if (done_cnt >= entry_limit) begin
          dec_ph = DecDone;
          break;
        end
        res[n] = '{KindFlag, done_cnt, 32'd0, b[i], 1'b0};
        n++;
        done_cnt = done_cnt + 16'd1;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expect_q.push_back(res[i]);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = 8'hFF;
      2: v = 8'h00;
      3: v = 8'h01 << $urandom_range(0, 7);
      4: v = ~(8'h01 << $urandom_range(0, 7));
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic idx, input logic [CountW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRemBits) rice_k = val[KW-1:0];
    else entry_limit = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (stream_q.size() != 0 || in_valid_i || expect_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // offer the next byte, at random unless calm, whenever the current beat is taken or none is up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      stream_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_byte(stream_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (stream_q.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          in_valid_i <= 1'b1;
          stream_byte_i <= stream_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // hold the output once for a long stretch, otherwise stall at random unless calm
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 16);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{kind_o, entry_index_o, offset_o, flag_o, last_o};
      if (expect_q.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10)
          $display("unexpected beat: kind %0d index %0d offset %h flag %0d last %0d",
                   seen.kind, seen.idx, seen.off, seen.flag, seen.last);
      end else begin
        want = expect_q.pop_front();
        if (seen.kind !== want.kind || seen.idx !== want.idx || seen.off !== want.off ||
            seen.flag !== want.flag || seen.last !== want.last) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display({"mismatch (expected/actual): kind %0d/%0d index %0d/%0d ",
                      "offset %h/%h flag %0d/%0d last %0d/%0d"},
                     want.kind, seen.kind, want.idx, seen.idx, want.off, seen.off,
                     want.flag, seen.flag, want.last, seen.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int            ph;
    int            n;
    int            f_cnt;
    logic [KW-1:0] k;
    bit            direct_end;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CfgRemBits, 16'd0);
    write_reg(CfgEntryCnt, 16'hFFFF);
    stream_q = '{8'h00, 8'hFF, 8'h02, 8'h55, 8'hAA, 8'h80, 8'h01, 8'h7F, 8'h00};
    wait_idle();
    write_reg(CfgRemBits, 16'd15);
    stream_q = '{8'hFF, 8'hFF, 8'h3E, 8'hC1, 8'h00, 8'hF0};
    wait_idle();
    write_reg(CfgRemBits, 16'd6);
    stream_q = '{8'hE0, 8'h1F, 8'h00, 8'h5A, 8'hA5};
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      k = (ph == 0) ? 4'd15 : ((ph == 1) ? 4'd0 : 4'($urandom_range(0, 15)));
      write_reg(CfgRemBits, {12'd0, k});
      if (ph == 5) write_reg(CfgEntryCnt, done_cnt + 16'($urandom_range(500, 2000)));
      calm = (ph == 3);
      n = $urandom_range(15, 25);
      repeat (n) stream_q.push_back(pick_byte());
      wait_idle();
    end
    calm = 1'b0;

    // if direct_end is set, align to an entry boundary at the head of a group so the table ends on bit 0
    direct_end = 1'($urandom_range(0, 1));
    if (direct_end) begin
      write_reg(CfgRemBits, 16'd0);
      while (in_rem || len_acc != 32'd1 || grp_pos != 2'd0) begin
        stream_q.push_back(in_rem ? 8'h80 : 8'h00);
        wait_idle();
      end
    end

    f_cnt = (done_cnt < 150) ? int'(done_cnt)
                             : $urandom_range(150, (done_cnt < 300) ? done_cnt : 300);
    write_reg(CfgEntryCnt, f_cnt[CountW-1:0]);
    @(negedge clk_i);
    hold_req = 1'b1;
    n = 0;
    while (dec_ph != DecDone && n < 40) begin
      repeat (16) stream_q.push_back(pick_byte());
      wait_idle();
      n++;
    end

    write_reg(CfgEntryCnt, 16'd0);
    write_reg(CfgRemBits, 16'($urandom_range(0, 15)));
    repeat (6) stream_q.push_back(pick_byte());
    wait_idle();

    if (miss_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ phrase_offset_rice_decoder.f @@
rtl/pord_pkg.sv
rtl/pord_front.sv
rtl/pord_queue.sv
rtl/pord_back.sv
rtl/phrase_offset_rice_decoder.sv
verif/phrase_offset_rice_decoder_test.sv
